// ===== design/xalu_pkg.sv =====
// Shared types, operation codes and helpers for the integer ALU with flags.
// Used by the front end, the queue, the execution unit and the top level.
package xalu_pkg;

   localparam int unsigned QueueDepth = 2;

   localparam logic [4:0] KIND_ADD  = 5'd0;
   localparam logic [4:0] KIND_ADC  = 5'd1;
   localparam logic [4:0] KIND_SUB  = 5'd2;
   localparam logic [4:0] KIND_SBB  = 5'd3;
   localparam logic [4:0] KIND_MUL  = 5'd4;
   localparam logic [4:0] KIND_IMUL = 5'd5;
   localparam logic [4:0] KIND_DIV  = 5'd6;
   localparam logic [4:0] KIND_IDIV = 5'd7;
   localparam logic [4:0] KIND_MOD  = 5'd8;
   localparam logic [4:0] KIND_IMOD = 5'd9;
   localparam logic [4:0] KIND_AND  = 5'd10;
   localparam logic [4:0] KIND_XOR  = 5'd11;
   localparam logic [4:0] KIND_OR   = 5'd12;
   localparam logic [4:0] KIND_SHL  = 5'd13;
   localparam logic [4:0] KIND_SHR  = 5'd14;
   localparam logic [4:0] KIND_SAR  = 5'd15;
   localparam logic [4:0] KIND_SAL  = 5'd16;

   // Operation class decided by the front end.
   localparam logic [2:0] CLS_ARITH = 3'd0;
   localparam logic [2:0] CLS_MUL   = 3'd1;
   localparam logic [2:0] CLS_DIV   = 3'd2;
   localparam logic [2:0] CLS_LOGIC = 3'd3;
   localparam logic [2:0] CLS_SHIFT = 3'd4;
   localparam logic [2:0] CLS_NONE  = 3'd5;

   typedef struct packed {
      logic [4:0]  kind;
      logic [2:0]  cls;
      logic [5:0]  w;        // operand width in bits: 8, 16 or 32
      logic [31:0] src;      // masked to the width, except a shift count, which is kept raw
      logic [63:0] dest;     // masked to the width, or to twice it for divides
   } op_type;

   typedef struct packed {
      logic [63:0] result;
      logic [4:0]  flags;
      logic        derr;
   } res_type;

   function automatic logic [63:0] mask64(input logic [6:0] bits);
      mask64 = (bits >= 7'd64) ? '1 : ((64'd1 << bits) - 64'd1);
   endfunction

   function automatic logic [63:0] sext64(input logic [63:0] x, input logic [6:0] bits);
      logic [63:0] m;
      m = mask64(bits);
      sext64 = (x & m) | ((bits < 7'd64 && x[bits[5:0] - 6'd1]) ? ~m : 64'd0);
   endfunction

endpackage

// ===== design/xalu_front.sv =====
// Front end: accepts a transaction, classifies the operation and masks operands.
// Depends on xalu_pkg.
module xalu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [4:0]         req_kind,
   input  logic [1:0]         req_width_sel,
   input  logic [31:0]        req_src_value,
   input  logic [63:0]        req_dest_value,
   output logic               op_valid,
   input  logic               op_ready,
   output xalu_pkg::op_type   op
);
   logic             valid_ff, valid_in;
   xalu_pkg::op_type op_ff, op_in;
   logic [5:0]       w;
   logic [63:0]      m;

   assign req_ready = !valid_ff || op_ready;
   assign op_valid  = valid_ff;
   assign op        = op_ff;

   always_comb begin
      unique case (req_width_sel)
         2'd0:    w = 6'd8;
         2'd1:    w = 6'd16;
         default: w = 6'd32;
      endcase
      m = xalu_pkg::mask64({1'b0, w});
      op_in.kind = req_kind;
      op_in.w    = w;
      priority if (req_kind <= xalu_pkg::KIND_SBB) op_in.cls = xalu_pkg::CLS_ARITH;
      else if (req_kind <= xalu_pkg::KIND_IMUL)    op_in.cls = xalu_pkg::CLS_MUL;
      else if (req_kind <= xalu_pkg::KIND_IMOD)    op_in.cls = xalu_pkg::CLS_DIV;
      else if (req_kind <= xalu_pkg::KIND_OR)      op_in.cls = xalu_pkg::CLS_LOGIC;
      else if (req_kind <= xalu_pkg::KIND_SAL)     op_in.cls = xalu_pkg::CLS_SHIFT;
      else                                         op_in.cls = xalu_pkg::CLS_NONE;
      op_in.src  = req_src_value;
      // Shifts need the raw count; everything else sees the masked source.
      if (op_in.cls != xalu_pkg::CLS_SHIFT) op_in.src = req_src_value & m[31:0];
      op_in.dest = (op_in.cls == xalu_pkg::CLS_DIV)
                   ? (req_dest_value & xalu_pkg::mask64({w, 1'b0}))
                   : (req_dest_value & m);
      valid_in = valid_ff;
      if (op_ready) valid_in = 1'b0;
      if (req_valid && req_ready) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (req_valid && req_ready) op_ff <= op_in;
   end
endmodule

// ===== design/xalu_queue.sv =====
// Short FIFO of classified operations between the front end and the execution unit.
// Depends on xalu_pkg.
module xalu_queue #(
   parameter int unsigned Depth = xalu_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  xalu_pkg::op_type in_op,
   output logic             out_valid,
   input  logic             out_ready,
   output xalu_pkg::op_type out_op
);
   localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
   xalu_pkg::op_type        mem_ff [Depth];
   logic [AW-1:0]           wp_ff, rp_ff;
   logic [$clog2(Depth+1)-1:0] cnt_ff;
   logic                    push, pop;

   assign in_ready  = cnt_ff != Depth[$clog2(Depth+1)-1:0];
   assign out_valid = cnt_ff != '0;
   assign out_op    = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
      if (push) mem_ff[wp_ff] <= in_op;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= Depth) else $error("queue count overflow");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("push lost");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> cnt_ff == $past(cnt_ff) - 1'b1) else $error("pop lost");
endmodule

// ===== design/xalu_exec.sv =====
// Execution unit: carries out one operation, keeps the flags register, and runs
// a one-bit-per-cycle restoring divider and a two-pass multiplier. Depends on xalu_pkg.
module xalu_exec (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   output logic              op_ready,
   input  xalu_pkg::op_type  op,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xalu_pkg::res_type rsp
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]        st_ff, st_in;
   logic [4:0]        flags_ff, flags_in;
   xalu_pkg::res_type res_ff, res_in;
   xalu_pkg::op_type  cur_ff, cur_in;
   logic [63:0]       quo_ff, quo_in;   // dividend shifting into quotient
   logic [32:0]       rem_ff, rem_in;
   logic [6:0]        step_ff, step_in;
   logic              na_ff, na_in, nb_ff, nb_in;
   logic [63:0]       prod_ff, prod_in;

   logic [63:0] m, sb, r, a, b, full, sub, x, p, rr, q;
   logic [6:0]  w7;
   logic [4:0]  cnt;
   logic        c, o, set_co, set_szp, signed_op;
   logic [33:0] trial;
   logic [4:0]  nf;

   assign op_ready  = (st_ff == ST_IDLE) && !rsp_valid;
   assign rsp_valid = (st_ff == ST_OUT);
   assign rsp       = res_ff;

   function automatic logic [4:0] szp(input logic [4:0] f, input logic [63:0] v,
                                      input logic [63:0] mk, input logic [63:0] sbit);
      logic [4:0] g;
      g    = f;
      g[1] = ~^v[7:0];
      g[2] = (v & mk) == 64'd0;
      g[3] = (v & sbit) != 64'd0;
      return g;
   endfunction

   always_comb begin
      st_in = st_ff; flags_in = flags_ff; res_in = res_ff; cur_in = cur_ff;
      quo_in = quo_ff; rem_in = rem_ff; step_in = step_ff;
      na_in = na_ff; nb_in = nb_ff; prod_in = prod_ff;
      w7 = {1'b0, cur_ff.w};
      m  = xalu_pkg::mask64({1'b0, op.w});
      sb = 64'd1 << (op.w - 6'd1);
      r = '0; c = 1'b0; o = 1'b0; set_co = 1'b0; set_szp = 1'b0;
      a = '0; b = '0; full = '0; sub = '0; x = '0; p = '0; rr = '0; q = '0;
      cnt = op.src[4:0]; trial = '0; nf = flags_ff;
      signed_op = (op.kind == xalu_pkg::KIND_IDIV) || (op.kind == xalu_pkg::KIND_IMOD);
      unique case (st_ff)
         ST_IDLE: begin
            if (op_valid && op_ready) begin
               cur_in = op;
               unique case (op.cls)
                  xalu_pkg::CLS_ARITH: begin
                     set_co = 1'b1; set_szp = 1'b1;
                     if (op.kind == xalu_pkg::KIND_ADD || op.kind == xalu_pkg::KIND_ADC) begin
                        full = op.dest + {32'd0, op.src}
                             + {63'd0, op.kind == xalu_pkg::KIND_ADC && flags_ff[0]};
                        r = full & m;
                        c = full[op.w];
                        o = ((~(op.dest ^ {32'd0, op.src})) & (op.dest ^ r) & sb) != 0;
                     end else begin
                        sub = {32'd0, op.src}
                            + {63'd0, op.kind == xalu_pkg::KIND_SBB && flags_ff[0]};
                        r = (op.dest - sub) & m;
                        c = op.dest < sub;
                        o = ((op.dest ^ {32'd0, op.src}) & (op.dest ^ r) & sb) != 0;
                     end
                  end
                  xalu_pkg::CLS_MUL: begin
                     // Operand registers; the product is formed in the next cycle.
                     st_in = ST_MUL;
                  end
                  xalu_pkg::CLS_DIV: begin
                     a = signed_op ? xalu_pkg::sext64(op.dest, {op.w, 1'b0}) : op.dest;
                     b = signed_op ? xalu_pkg::sext64({32'd0, op.src}, {1'b0, op.w})
                                   : {32'd0, op.src};
                     na_in = signed_op && a[63];
                     nb_in = signed_op && b[63];
                     quo_in = na_in ? (64'd0 - a) : a;
                     // The divisor magnitude fits 32 bits; keep it in cur.src.
                     cur_in.src = nb_in ? (32'd0 - b[31:0]) : b[31:0];
                     rem_in = '0;
                     step_in = '0;
                     if (op.src == 32'd0) begin
                        res_in.result = '0; res_in.flags = flags_ff; res_in.derr = 1'b1;
                        st_in = ST_OUT;
                     end else begin
                        st_in = ST_DIV;
                     end
                  end
                  xalu_pkg::CLS_LOGIC: begin
                     set_co = 1'b1; set_szp = 1'b1;
                     unique case (op.kind)
                        xalu_pkg::KIND_AND: r = op.dest & {32'd0, op.src};
                        xalu_pkg::KIND_XOR: r = op.dest ^ {32'd0, op.src};
                        default:            r = op.dest | {32'd0, op.src};
                     endcase
                  end
                  xalu_pkg::CLS_SHIFT: begin
                     if (cnt == 5'd0) begin
                        r = op.dest;
                     end else begin
                        set_co = 1'b1; set_szp = 1'b1;
                        if (op.kind == xalu_pkg::KIND_SHR) begin
                           r = op.dest >> cnt;
                           c = op.dest[cnt - 5'd1];
                           o = op.dest[op.w - 6'd1];
                        end else if (op.kind == xalu_pkg::KIND_SAR) begin
                           x = xalu_pkg::sext64(op.dest, {1'b0, op.w});
                           r = ($signed(x) >>> cnt) & m;
                           rr = $signed(x) >>> (cnt - 5'd1);
                           c = rr[0];
                        end else begin
                           r = (op.dest << cnt) & m;
                           rr = op.dest << (cnt - 5'd1);
                           c = rr[op.w - 6'd1];
                           o = r[op.w - 6'd1] ^ c;
                        end
                     end
                  end
                  default: r = '0;
               endcase
               if (set_co) begin nf[0] = c; nf[4] = o; end
               if (set_szp) nf = szp(nf, r, m, sb);
               if (op.cls != xalu_pkg::CLS_MUL && op.cls != xalu_pkg::CLS_DIV) begin
                  flags_in = nf;
                  res_in.result = r; res_in.flags = nf; res_in.derr = 1'b0;
                  st_in = ST_OUT;
               end
            end
         end
         ST_MUL: begin
            if (step_ff == 7'd0) begin
               a = cur_ff.kind == xalu_pkg::KIND_IMUL
                   ? xalu_pkg::sext64(cur_ff.dest, w7) : cur_ff.dest;
               b = cur_ff.kind == xalu_pkg::KIND_IMUL
                   ? xalu_pkg::sext64({32'd0, cur_ff.src}, w7) : {32'd0, cur_ff.src};
               // Low 64 bits of the product from one 32x32 multiply; a negative
               // operand subtracts the other operand shifted up by 32.
               prod_in = (a[31:0] * b[31:0])
                       - (a[63] ? {b[31:0], 32'd0} : 64'd0)
                       - (b[63] ? {a[31:0], 32'd0} : 64'd0);
               step_in = 7'd1;
            end else begin
               p = prod_ff & xalu_pkg::mask64({w7[5:0], 1'b0});
               if (cur_ff.kind == xalu_pkg::KIND_IMUL)
                  c = xalu_pkg::sext64(p, {w7[5:0], 1'b0}) != xalu_pkg::sext64(p, w7);
               else
                  c = (p >> w7) != 64'd0;
               nf[0] = c; nf[4] = c;
               flags_in = nf;
               res_in.result = p; res_in.flags = nf; res_in.derr = 1'b0;
               step_in = '0;
               st_in = ST_OUT;
            end
         end
         ST_DIV: begin
            trial = {rem_ff, quo_ff[63]} - {2'b00, cur_ff.src};
            if (!trial[33]) rem_in = trial[32:0];
            else            rem_in = {rem_ff[31:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], !trial[33]};
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd63) begin
               q  = na_ff ^ nb_ff ? 64'd0 - quo_in : quo_in;
               rr = na_ff ? 64'd0 - {31'd0, rem_in} : {31'd0, rem_in};
               res_in.result = ((cur_ff.kind == xalu_pkg::KIND_DIV ||
                                 cur_ff.kind == xalu_pkg::KIND_IDIV) ? q : rr)
                               & xalu_pkg::mask64(w7);
               res_in.flags = flags_ff; res_in.derr = 1'b0;
               step_in = '0;
               st_in = ST_OUT;
            end
         end
         default: if (rsp_ready) st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; flags_ff <= '0; step_ff <= '0;
      end else begin
         st_ff <= st_in; flags_ff <= flags_in; step_ff <= step_in;
      end
      res_ff <= res_in; cur_ff <= cur_in; quo_ff <= quo_in; rem_ff <= rem_in;
      na_ff <= na_in; nb_ff <= nb_in; prod_ff <= prod_in;
   end

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_ff)) else $error("result dropped");
   a_div_flags: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_DIV |=> $stable(flags_ff)) else $error("flags changed in divide");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_IDLE |-> !op_ready) else $error("accept while busy");
endmodule

// ===== design/x86_integer_alu_with_flags.sv =====
// Top level of the integer ALU with flags: front end, queue and execution unit.
// Depends on xalu_pkg, xalu_front, xalu_queue and xalu_exec.
//
// One operation per transaction with CF, PF, ZF, SF and OF kept across
// transactions. In the execution unit, add, subtract, logic and shift kinds are
// computed, then presented; multiplies pass through operand capture, 32x32
// product and fit test, then are presented; divide and modulo kinds run through
// the restoring divider, which retires one quotient bit per cycle over the
// 64-bit dividend. A zero divisor is reported without entering the divider.
// The front end and the two-entry queue accept while the execution unit is busy.
module x86_integer_alu_with_flags #(
   parameter int unsigned QueueDepth = xalu_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_kind,
   input  logic [1:0]  req_width_sel,
   input  logic [31:0] req_src_value,
   input  logic [63:0] req_dest_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result,
   output logic        rsp_carry_flag,
   output logic        rsp_parity_flag,
   output logic        rsp_zero_flag,
   output logic        rsp_sign_flag,
   output logic        rsp_overflow_flag,
   output logic        rsp_divide_error
);
   logic              f_valid, f_ready, e_valid, e_ready;
   xalu_pkg::op_type  f_op, e_op;
   xalu_pkg::res_type res;

   xalu_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_width_sel,
      .req_src_value, .req_dest_value,
      .op_valid(f_valid), .op_ready(f_ready), .op(f_op)
   );

   xalu_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_op(f_op),
      .out_valid(e_valid), .out_ready(e_ready), .out_op(e_op)
   );

   xalu_exec u_exec (
      .clock, .reset, .op_valid(e_valid), .op_ready(e_ready), .op(e_op),
      .rsp_valid, .rsp_ready, .rsp(res)
   );

   assign rsp_result        = res.result;
   assign rsp_carry_flag    = res.flags[0];
   assign rsp_parity_flag   = res.flags[1];
   assign rsp_zero_flag     = res.flags[2];
   assign rsp_sign_flag     = res.flags[3];
   assign rsp_overflow_flag = res.flags[4];
   assign rsp_divide_error  = res.derr;
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the x86 integer ALU with flags (x86_integer_alu_with_flags).
// Needs xalu_pkg for opcodes; it predicts results and flags or takes them from a table.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [4:0]  req_kind;
   logic [1:0]  req_width_sel;
   logic [31:0] req_src_value;
   logic [63:0] req_dest_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_result;
   logic        rsp_carry_flag, rsp_parity_flag, rsp_zero_flag;
   logic        rsp_sign_flag, rsp_overflow_flag, rsp_divide_error;

   x86_integer_alu_with_flags u_top (.*);

   typedef struct {
      logic [63:0] result;
      logic [4:0]  flags;   // {OF, SF, ZF, PF, CF}
      logic        derr;
   } alu_out_type;

   typedef struct {
      logic [4:0]  kind;
      logic [1:0]  ws;
      logic [31:0] src;
      logic [63:0] dest;
      logic        typed;
      logic [63:0] result;
      logic [4:0]  flags;
      logic        derr;
   } vector_type;

   alu_out_type pending_results[$];
   logic [4:0]  model_flags;
   int          failures;
   int          sent, received;
   int          send_idle_pct, recv_stall_pct;
   int          hold_cycles;

   function automatic logic [63:0] width_mask(int bits);
      return (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
   endfunction

   function automatic logic [63:0] extend_sign(logic [63:0] x, int bits);
      logic [63:0] m;
      m = width_mask(bits);
      x &= m;
      if (bits < 64 && x[bits-1]) x |= ~m;
      return x;
   endfunction

   // Computes the next result and updates the flag image carried across transactions.
   function automatic alu_out_type alu_predict(logic [4:0] kind, logic [1:0] ws,
                                               logic [31:0] src, logic [63:0] dest);
      alu_out_type o;
      int w, cnt;
      logic [63:0] m, sb, sm, dm, r, full, sub, p, a, b, ma, mb, q, x;
      logic c, ov, derr, set_co, set_szp, na, nb;
      w = (ws == 2'd0) ? 8 : (ws == 2'd1) ? 16 : 32;
      m = width_mask(w);
      sb = 64'd1 << (w - 1);
      sm = {32'd0, src} & m;
      dm = dest & m;
      r = 0; c = 0; ov = 0; derr = 0; set_co = 0; set_szp = 0;
      case (kind)
         xalu_pkg::KIND_ADD, xalu_pkg::KIND_ADC: begin
            full = dm + sm + ((kind == xalu_pkg::KIND_ADC) ? {63'd0, model_flags[0]} : 64'd0);
            r = full & m;
            c = full[w];
            ov = ((~(dm ^ sm)) & (dm ^ r) & sb) != 0;
            set_co = 1; set_szp = 1;
         end
         xalu_pkg::KIND_SUB, xalu_pkg::KIND_SBB: begin
            sub = sm + ((kind == xalu_pkg::KIND_SBB) ? {63'd0, model_flags[0]} : 64'd0);
            r = (dm - sub) & m;
            c = dm < sub;
            ov = ((dm ^ sm) & (dm ^ r) & sb) != 0;
            set_co = 1; set_szp = 1;
         end
         xalu_pkg::KIND_MUL: begin
            p = dm * sm;
            r = p & width_mask(2 * w);
            c = (p >> w) != 0; ov = c;
            set_co = 1;
         end
         xalu_pkg::KIND_IMUL: begin
            p = extend_sign(dm, w) * extend_sign(sm, w);
            r = p & width_mask(2 * w);
            c = extend_sign(p, w) != p; ov = c;
            set_co = 1;
         end
         xalu_pkg::KIND_DIV, xalu_pkg::KIND_MOD: begin
            if (sm == 0) derr = 1;
            else r = ((kind == xalu_pkg::KIND_DIV) ? (dest & width_mask(2 * w)) / sm
                                                   : (dest & width_mask(2 * w)) % sm) & m;
         end
         xalu_pkg::KIND_IDIV, xalu_pkg::KIND_IMOD: begin
            a = extend_sign(dest, 2 * w); b = extend_sign(sm, w);
            na = a[63]; nb = b[63];
            ma = na ? -a : a; mb = nb ? -b : b;
            if (mb == 0) derr = 1;
            else if (kind == xalu_pkg::KIND_IDIV) begin
               q = ma / mb;
               r = ((na ^ nb) ? -q : q) & m;
            end else begin
               q = ma % mb;
               r = (na ? -q : q) & m;
            end
         end
         xalu_pkg::KIND_AND, xalu_pkg::KIND_XOR, xalu_pkg::KIND_OR: begin
            r = (kind == xalu_pkg::KIND_AND) ? (dm & sm)
              : (kind == xalu_pkg::KIND_XOR) ? (dm ^ sm) : (dm | sm);
            set_co = 1; set_szp = 1;
         end
         xalu_pkg::KIND_SHL, xalu_pkg::KIND_SAL, xalu_pkg::KIND_SHR, xalu_pkg::KIND_SAR: begin
            cnt = src[4:0];
            if (cnt == 0) r = dm;
            else begin
               if (kind == xalu_pkg::KIND_SHL || kind == xalu_pkg::KIND_SAL) begin
                  r = (dm << cnt) & m;
                  q = dm << (cnt - 1);
                  c = q[w-1];
                  ov = r[w-1] ^ c;
               end else if (kind == xalu_pkg::KIND_SHR) begin
                  r = dm >> cnt;
                  c = dm[cnt-1];
                  ov = dm[w-1];
               end else begin
                  x = extend_sign(dm, w);
                  r = ($signed(x) >>> cnt) & m;
                  q = $signed(x) >>> (cnt - 1);
                  c = q[0];
               end
               set_co = 1; set_szp = 1;
            end
         end
         default: ;
      endcase
      if (set_co) begin
         model_flags[0] = c;
         model_flags[4] = ov;
      end
      if (set_szp) begin
         model_flags[1] = ~^r[7:0];
         model_flags[2] = (r & m) == 0;
         model_flags[3] = (r & sb) != 0;
      end
      o.result = r; o.flags = model_flags; o.derr = derr;
      return o;
   endfunction

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   // Sender: offers one transaction, waits for its acceptance and queues its expected result.
   task automatic send_expect(logic [4:0] kind, logic [1:0] ws, logic [31:0] src,
                              logic [63:0] dest, alu_out_type e);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind; req_width_sel <= ws;
      req_src_value <= src; req_dest_value <= dest;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(e);
      sent++;
   endtask

   task automatic send_op(logic [4:0] kind, logic [1:0] ws, logic [31:0] src, logic [63:0] dest);
      send_expect(kind, ws, src, dest, alu_predict(kind, ws, src, dest));
   endtask

   // Receiver: random stall, with one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      alu_out_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         received++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transaction, result %h", $time, rsp_result);
            failures++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_result !== e.result) begin
               $display("%0t: result expected %h actual %h", $time, e.result, rsp_result);
               failures++;
            end
            if ({rsp_overflow_flag, rsp_sign_flag, rsp_zero_flag, rsp_parity_flag,
                 rsp_carry_flag} !== e.flags) begin
               $display("%0t: flags OSZPC expected %b actual %b", $time, e.flags,
                        {rsp_overflow_flag, rsp_sign_flag, rsp_zero_flag, rsp_parity_flag,
                         rsp_carry_flag});
               failures++;
            end
            if (rsp_divide_error !== e.derr) begin
               $display("%0t: divide_error expected %b actual %b", $time, e.derr,
                        rsp_divide_error);
               failures++;
            end
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Operands biased toward the edges of each width, where carries and overflows happen.
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(5))
         0: return 64'd0;
         1: return '1;
         2: return 64'h80 << (8 * $urandom_range(3));
         3: return (64'h7F << (8 * $urandom_range(3))) | 64'hFF;
         4: return $urandom_range(15);
         default: return rand64();
      endcase
   endfunction

   vector_type directed[] = '{
      // ADD 0+0: zero and parity set.
      '{xalu_pkg::KIND_ADD, 2'd0, 32'h0, 64'h0, 1, 64'h0, 5'b00110, 0},
      // 0xFF + 1 at 8 bits: carry out, zero.
      '{xalu_pkg::KIND_ADD, 2'd0, 32'h1, 64'hFF, 1, 64'h0, 5'b00111, 0},
      // Zero divisor: result zero, error raised, flags kept.
      '{xalu_pkg::KIND_DIV, 2'd0, 32'h0, 64'h1234, 1, 64'h0, 5'b00111, 1},
      '{xalu_pkg::KIND_ADC, 2'd0, 32'h7F, 64'h0, 0, 0, 0, 0},
      '{xalu_pkg::KIND_ADD, 2'd1, 32'h7FFF, 64'h1, 0, 0, 0, 0},
      '{xalu_pkg::KIND_SUB, 2'd2, 32'h1, 64'h0, 0, 0, 0, 0},
      '{xalu_pkg::KIND_SBB, 2'd2, 32'hFFFFFFFF, 64'hFFFFFFFF, 0, 0, 0, 0},
      '{xalu_pkg::KIND_MUL, 2'd2, 32'hFFFFFFFF, 64'hFFFFFFFF, 0, 0, 0, 0},
      '{xalu_pkg::KIND_IMUL, 2'd0, 32'h80, 64'h80, 0, 0, 0, 0},
      '{xalu_pkg::KIND_IMUL, 2'd1, 32'hFFFF, 64'h7FFF, 0, 0, 0, 0},
      '{xalu_pkg::KIND_DIV, 2'd2, 32'h3, 64'hFFFFFFFFFFFFFFFF, 0, 0, 0, 0},
      '{xalu_pkg::KIND_IDIV, 2'd0, 32'hFF, 64'h8000, 0, 0, 0, 0},
      '{xalu_pkg::KIND_MOD, 2'd1, 32'h7, 64'hFFFFFFFF, 0, 0, 0, 0},
      '{xalu_pkg::KIND_IMOD, 2'd2, 32'hFFFFFFF9, 64'h8000000000000001, 0, 0, 0, 0},
      '{xalu_pkg::KIND_AND, 2'd2, 32'hF0F0F0F0, 64'hFFFFFFFF, 0, 0, 0, 0},
      '{xalu_pkg::KIND_XOR, 2'd1, 32'hFFFF, 64'hFFFF, 0, 0, 0, 0},
      '{xalu_pkg::KIND_OR, 2'd3, 32'h80000000, 64'h0, 0, 0, 0, 0},
      '{xalu_pkg::KIND_SHL, 2'd0, 32'h0, 64'hFFFFFFFFFFFFFFFF, 0, 0, 0, 0},
      '{xalu_pkg::KIND_SHL, 2'd0, 32'h9, 64'hFF, 0, 0, 0, 0},
      '{xalu_pkg::KIND_SAL, 2'd2, 32'h1F, 64'h3, 0, 0, 0, 0},
      '{xalu_pkg::KIND_SHR, 2'd1, 32'h11, 64'h8000, 0, 0, 0, 0},
      '{xalu_pkg::KIND_SAR, 2'd0, 32'h1F, 64'h80, 0, 0, 0, 0},
      '{xalu_pkg::KIND_SAR, 2'd2, 32'hE1, 64'h7FFFFFFF, 0, 0, 0, 0},
      '{5'd31, 2'd2, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 0, 0, 0, 0}
   };

   initial begin
      int k, phase, guard;
      logic [4:0] kind;
      alu_out_type e;
      failures = 0; sent = 0; received = 0;
      model_flags = '0;
      send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
      reset <= 1; req_valid <= 0;
      req_kind <= '0; req_width_sel <= '0; req_src_value <= '0; req_dest_value <= '0;
      repeat (2) @(posedge clock);
      reset <= 0;

      foreach (directed[i]) begin
         if (directed[i].typed) begin
            // The predictor still runs so the flag image stays in step.
            e = alu_predict(directed[i].kind, directed[i].ws, directed[i].src,
                            directed[i].dest);
            e.result = directed[i].result;
            e.flags  = directed[i].flags;
            e.derr   = directed[i].derr;
            send_expect(directed[i].kind, directed[i].ws, directed[i].src,
                        directed[i].dest, e);
         end else begin
            send_op(directed[i].kind, directed[i].ws, directed[i].src, directed[i].dest);
         end
      end

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            3: begin send_idle_pct = 14; recv_stall_pct = 14; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (phase == 4) hold_cycles = 300;
         for (k = 0; k < 385; k++) begin
            // Mostly fast kinds so the long divides do not dominate run time.
            kind = ($urandom_range(9) == 0)
                 ? 5'($urandom_range(xalu_pkg::KIND_DIV, xalu_pkg::KIND_IMOD))
                 : ($urandom_range(40) == 0) ? 5'($urandom_range(17, 31))
                 : 5'($urandom_range(xalu_pkg::KIND_SAL));
            if (kind >= xalu_pkg::KIND_DIV && kind <= xalu_pkg::KIND_IMOD &&
                $urandom_range(5) != 0)
               send_op(kind, 2'($urandom_range(3)), 32'($urandom_range(1, 255)) | $urandom,
                       pick_operand());
            else
               send_op(kind, 2'($urandom_range(3)), pick_operand(), pick_operand());
         end
      end
      req_valid <= 0;

      guard = 0;
      while (pending_results.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (100) @(posedge clock);
      $display("Ran %0d transactions, %0d results, directed edges plus five idling phases.",
               sent, received);
      if (failures == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/xalu_pkg.sv
design/xalu_front.sv
design/xalu_queue.sv
design/xalu_exec.sv
design/x86_integer_alu_with_flags.sv
tb/testbench.sv
